FILE: rtl/core/actuator_feedback_controller_defines.svh
// assertion macros of the actuator feedback controller rtl
// no dependencies; files that assert include this header by name
`ifndef ACTUATOR_FEEDBACK_CONTROLLER_DEFINES_SVH
`define ACTUATOR_FEEDBACK_CONTROLLER_DEFINES_SVH

// implication checked on every rising clk edge outside reset
`define AFC_ASSERT_IMPL(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication checked on every rising clk edge outside reset
`define AFC_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/core/afc_pkg.sv
// types and constants of the actuator feedback controller
// no dependencies; used by every module of the block
package afc_pkg;

	// apb address and data widths
	localparam int AddrW = 5;
	localparam int DataW = 32;
	// width of the phase time registers
	localparam int PhaseTimeW = 16;

	// register indexes (byte address is 4 * index)
	localparam logic [2:0] REG_FEEDBACK_TYPE   = 3'd0;
	localparam logic [2:0] REG_ACTUATION_TYPE  = 3'd1;
	localparam logic [2:0] REG_ENABLE_PRESET   = 3'd2;
	localparam logic [2:0] REG_ENABLE_TIME     = 3'd3;
	localparam logic [2:0] REG_DISABLE_TIME    = 3'd4;
	localparam logic [2:0] REG_DIAG_ENABLE     = 3'd5;

	// feedback type codes
	localparam logic [1:0] FB_BOTH         = 2'd0;
	localparam logic [1:0] FB_ENABLE_ONLY  = 2'd1;
	localparam logic [1:0] FB_DISABLE_ONLY = 2'd2;
	localparam logic [1:0] FB_NONE         = 2'd3;

	// actuation type codes, the unused code behaves as single
	localparam logic [1:0] ACT_SINGLE   = 2'd0;
	localparam logic [1:0] ACT_RETAINED = 2'd1;
	localparam logic [1:0] ACT_PHASED   = 2'd2;

	// phase of the actuator
	typedef enum logic [1:0] {
		PH_DISABLED  = 2'd0,
		PH_ENABLING  = 2'd1,
		PH_ENABLED   = 2'd2,
		PH_DISABLING = 2'd3
	} phase_t;

	// configuration registers as seen by the step logic
	typedef struct packed {
		logic [1:0]            feedback_type;
		logic [1:0]            actuation_type;
		logic                  enable_preset;
		logic [PhaseTimeW-1:0] enable_time;
		logic [PhaseTimeW-1:0] disable_time;
		logic                  diagnostics_enable;
	} cfg_t;

	// input word
	typedef struct packed {
		logic cmd;
		logic enabled_sensor;
		logic disabled_sensor;
		logic clock_tick;
		logic enable_request;
		logic disable_request;
		logic external_fault;
	} item_t;

	// result word
	typedef struct packed {
		logic [1:0] status;
		logic       enable_out;
		logic       disable_out;
		logic       enabled_feedback;
		logic       disabled_feedback;
		logic       disabled_sensor_fault;
		logic       enabled_sensor_fault;
		logic       actuator_fault;
		logic       any_fault;
		logic       enable_req_clear;
		logic       disable_req_clear;
		logic       not_initialized;
	} result_t;

endpackage

FILE: rtl/core/afc_regs.sv
// apb configuration register file of the actuator feedback controller
// depends on afc_pkg
module afc_regs (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [afc_pkg::AddrW-1:0] paddr,
	input  logic [afc_pkg::DataW-1:0] pwdata,
	output logic [afc_pkg::DataW-1:0] prdata,
	output logic                      pready,
	output afc_pkg::cfg_t             cfg
);
	import afc_pkg::*;

	cfg_t       cfg_q;
	logic [2:0] reg_idx;
	logic       wr_en;

	assign reg_idx = paddr[AddrW-1:2];
	assign wr_en   = psel && penable && pwrite;
	assign pready  = 1'b1;
	assign cfg     = cfg_q;

	// register writes, indexes beyond the list are dropped
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q <= '0;
		end else if (wr_en) begin
			case (reg_idx)
				REG_FEEDBACK_TYPE:  cfg_q.feedback_type      <= pwdata[1:0];
				REG_ACTUATION_TYPE: cfg_q.actuation_type     <= pwdata[1:0];
				REG_ENABLE_PRESET:  cfg_q.enable_preset      <= pwdata[0];
				REG_ENABLE_TIME:    cfg_q.enable_time        <= pwdata[PhaseTimeW-1:0];
				REG_DISABLE_TIME:   cfg_q.disable_time       <= pwdata[PhaseTimeW-1:0];
				REG_DIAG_ENABLE:    cfg_q.diagnostics_enable <= pwdata[0];
				default: ;
			endcase
		end
	end

	// read mux
	always_comb begin
		prdata = '0;
		case (reg_idx)
			REG_FEEDBACK_TYPE:  prdata = DataW'(cfg_q.feedback_type);
			REG_ACTUATION_TYPE: prdata = DataW'(cfg_q.actuation_type);
			REG_ENABLE_PRESET:  prdata = DataW'(cfg_q.enable_preset);
			REG_ENABLE_TIME:    prdata = DataW'(cfg_q.enable_time);
			REG_DISABLE_TIME:   prdata = DataW'(cfg_q.disable_time);
			REG_DIAG_ENABLE:    prdata = DataW'(cfg_q.diagnostics_enable);
			default:            prdata = '0;
		endcase
	end

endmodule

FILE: rtl/core/afc_step.sv
// per-word step logic and actuator state registers of the feedback controller
// depends on afc_pkg and actuator_feedback_controller_defines.svh
`include "actuator_feedback_controller_defines.svh"

module afc_step #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             fire,
	input  afc_pkg::item_t   item,
	input  afc_pkg::cfg_t    cfg,
	output afc_pkg::result_t res
);
	import afc_pkg::*;

	phase_t                 phase_q, phase_d;
	logic                   cmd_q, cmd_d;
	logic [TIMER_WIDTH-1:0] timer_q, timer_d;
	logic                   init_q, init_d;

	logic [TIMER_WIDTH-1:0] timer_dec;
	logic [TIMER_WIDTH-1:0] load_en, load_dis;
	logic                   tmo, st_en, st_dis;
	logic                   en_fb, dis_fb, clr_en, clr_dis;
	logic                   f_dis, f_en, f_act;
	logic                   en_out, dis_out;

	// phase time saturates when the timer is narrower than the register
	function automatic logic [TIMER_WIDTH-1:0] timer_load(input logic [PhaseTimeW-1:0] t);
		logic [31:0] wide;
		wide = 32'(t);
		return (|(wide >> TIMER_WIDTH)) ? '1 : TIMER_WIDTH'(t);
	endfunction

	assign load_en  = timer_load(cfg.enable_time);
	assign load_dis = timer_load(cfg.disable_time);

	// timer count down and timeout of the current phase
	assign timer_dec = (item.clock_tick && timer_q != '0) ? timer_q - 1'b1 : timer_q;
	assign tmo       = (timer_dec == '0);
	assign st_en     = (phase_q == PH_ENABLED)  || (phase_q == PH_ENABLING && tmo);
	assign st_dis    = (phase_q == PH_DISABLED) || (phase_q == PH_DISABLING && tmo);

	// feedback, phase machine and fault detection
	always_comb begin
		phase_d = phase_q;
		cmd_d   = cmd_q;
		timer_d = timer_q;
		init_d  = init_q;
		clr_en  = 1'b0;
		clr_dis = 1'b0;
		f_dis   = 1'b0;
		f_en    = 1'b0;
		f_act   = 1'b0;
		en_fb   = 1'b0;
		dis_fb  = 1'b0;
		if (item.cmd) begin
			// init preset
			case (cfg.feedback_type)
				FB_BOTH: begin
					en_fb  = item.enabled_sensor;
					dis_fb = item.disabled_sensor;
				end
				FB_ENABLE_ONLY: begin
					en_fb  = item.enabled_sensor;
					dis_fb = !item.enabled_sensor;
				end
				FB_DISABLE_ONLY: begin
					dis_fb = item.disabled_sensor;
					en_fb  = !item.disabled_sensor;
				end
				default: begin
					en_fb  = cfg.enable_preset;
					dis_fb = !cfg.enable_preset;
				end
			endcase
			clr_en  = 1'b1;
			clr_dis = 1'b1;
			if (cfg.enable_preset) begin
				cmd_d   = 1'b1;
				timer_d = load_en;
				phase_d = en_fb ? PH_ENABLED : PH_ENABLING;
				init_d  = !en_fb;
			end else begin
				cmd_d   = 1'b0;
				timer_d = load_dis;
				phase_d = dis_fb ? PH_DISABLED : PH_DISABLING;
				init_d  = !dis_fb;
			end
		end else begin
			// scan
			timer_d = timer_dec;
			case (cfg.feedback_type)
				FB_BOTH: begin
					en_fb  = item.enabled_sensor;
					dis_fb = item.disabled_sensor;
				end
				FB_ENABLE_ONLY: begin
					en_fb  = item.enabled_sensor;
					dis_fb = !item.enabled_sensor && st_dis;
				end
				FB_DISABLE_ONLY: begin
					dis_fb = item.disabled_sensor;
					en_fb  = !item.disabled_sensor && st_en;
				end
				default: begin
					en_fb  = st_en;
					dis_fb = st_dis;
				end
			endcase

			case (phase_q)
				PH_DISABLED: begin
					clr_dis = 1'b1;
					if (item.enable_request) begin
						cmd_d   = 1'b1;
						timer_d = load_en;
						phase_d = PH_ENABLING;
					end
				end
				PH_ENABLING: begin
					if (item.disable_request) begin
						clr_en  = 1'b1;
						cmd_d   = 1'b0;
						timer_d = load_dis;
						phase_d = PH_DISABLING;
					end else if (en_fb) begin
						clr_en  = 1'b1;
						timer_d = '0;
						phase_d = PH_ENABLED;
					end
				end
				PH_ENABLED: begin
					clr_en = 1'b1;
					if (item.disable_request) begin
						cmd_d   = 1'b0;
						timer_d = load_dis;
						phase_d = PH_DISABLING;
					end
				end
				default: begin
					if (item.enable_request) begin
						clr_dis = 1'b1;
						cmd_d   = 1'b1;
						timer_d = load_en;
						phase_d = PH_ENABLING;
					end else if (dis_fb) begin
						clr_dis = 1'b1;
						timer_d = '0;
						phase_d = PH_DISABLED;
					end
				end
			endcase

			// faults judged at timeout against the new command
			if (cfg.diagnostics_enable && tmo) begin
				f_dis = (!cmd_d && !dis_fb && !en_fb) || (cmd_d && dis_fb && en_fb);
				f_en  = (!cmd_d && dis_fb && en_fb) || (cmd_d && !dis_fb && !en_fb);
				f_act = (!cmd_d && !dis_fb && en_fb) || (cmd_d && dis_fb && !en_fb);
			end
		end
	end

	// drive shaping by actuation type
	always_comb begin
		en_out  = cmd_d;
		dis_out = 1'b0;
		case (cfg.actuation_type)
			ACT_RETAINED: begin
				en_out  = cmd_d;
				dis_out = !cmd_d;
			end
			ACT_PHASED: begin
				en_out  = cmd_d && (phase_d == PH_ENABLING);
				dis_out = !en_out && (phase_d == PH_DISABLING);
			end
			default: begin
				en_out  = cmd_d;
				dis_out = 1'b0;
			end
		endcase
	end

	// result word
	always_comb begin
		res.status                = phase_d;
		res.enable_out            = en_out;
		res.disable_out           = dis_out;
		res.enabled_feedback      = en_fb;
		res.disabled_feedback     = dis_fb;
		res.disabled_sensor_fault = f_dis;
		res.enabled_sensor_fault  = f_en;
		res.actuator_fault        = f_act;
		res.any_fault             = f_dis | f_en | f_act | item.external_fault;
		res.enable_req_clear      = clr_en;
		res.disable_req_clear     = clr_dis;
		res.not_initialized       = init_d;
	end

	// state registers, updated once per word
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_DISABLED;
			cmd_q   <= 1'b0;
			timer_q <= '0;
			init_q  <= 1'b1;
		end else if (fire) begin
			phase_q <= phase_d;
			cmd_q   <= cmd_d;
			timer_q <= timer_d;
			init_q  <= init_d;
		end
	end

	// enabled phase holds across a scan without a disable request
	`AFC_ASSERT_NEXT(a_enabled_holds,
		fire && !item.cmd && phase_q == PH_ENABLED && !item.disable_request,
		phase_q == PH_ENABLED, "enabled phase left without disable request")

	// scan never changes the init pending flag
	`AFC_ASSERT_NEXT(a_scan_keeps_init,
		fire && !item.cmd, init_q == $past(init_q), "scan changed init pending flag")

	// the two drives are never asserted together
	`AFC_ASSERT_IMPL(a_drive_exclusive,
		fire, !(res.enable_out && res.disable_out), "enable and disable drive both high")

	// reaching the enabled phase on a scan leaves the timer cleared
	`AFC_ASSERT_NEXT(a_settle_clears_timer,
		fire && !item.cmd && phase_q == PH_ENABLING && !item.disable_request && en_fb,
		timer_q == '0, "timer not cleared on reaching enabled")

endmodule

FILE: rtl/core/actuator_feedback_controller.sv
// Actuator feedback controller, top level.
// Input channel item_valid/item_ready/item carries one word per scan or
// init command; result channel result_valid/result_ready/result returns
// exactly one result word for each input word, in order.
// Configuration goes through an apb-style port (byte address 4 * register
// index, pready tied high, no wait states); the user must write it only
// while idle, the block does not enforce this. A word is accepted into an
// input register, the step logic runs on it there and the result register
// holds its result; the result register loads from the input register
// when it is empty or its word is taken. One word per cycle is sustained
// while result_ready is high, set by the single pass through step logic.
// When result_ready is low the result register holds its word and the
// input register still takes one more word; after that item_ready drops
// until the result is taken.
// Reset clears the configuration to zero, the phase to disabled, the
// command and timer to zero and sets the not-initialized flag; both
// pipeline registers come out of reset empty.
// depends on afc_pkg, afc_regs, afc_step
module actuator_feedback_controller #(
	parameter int TIMER_WIDTH = 16
) (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      item_valid,
	output logic                      item_ready,
	input  afc_pkg::item_t            item,
	output logic                      result_valid,
	input  logic                      result_ready,
	output afc_pkg::result_t          result,
	input  logic                      psel,
	input  logic                      penable,
	input  logic                      pwrite,
	input  logic [afc_pkg::AddrW-1:0] paddr,
	input  logic [afc_pkg::DataW-1:0] pwdata,
	output logic [afc_pkg::DataW-1:0] prdata,
	output logic                      pready
);
	import afc_pkg::*;

	cfg_t    cfg;
	item_t   item_s1;
	logic    vld_s1;
	result_t res;
	result_t result_q;
	logic    result_vld_q;
	logic    out_take, adv_s1;

	// handshake between the two register stages
	assign out_take   = !result_vld_q || result_ready;
	assign adv_s1     = vld_s1 && out_take;
	assign item_ready = !vld_s1 || adv_s1;

	// configuration registers
	afc_regs u_regs (
		.clk     (clk),
		.arst_n  (arst_n),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready),
		.cfg     (cfg)
	);

	// step logic with the actuator state
	afc_step #(
		.TIMER_WIDTH (TIMER_WIDTH)
	) u_step (
		.clk    (clk),
		.arst_n (arst_n),
		.fire   (adv_s1),
		.item   (item_s1),
		.cfg    (cfg),
		.res    (res)
	);

	// input register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else if (item_ready) begin
			vld_s1 <= item_valid;
		end
	end

	// input register word
	always_ff @(posedge clk) begin
		if (item_ready && item_valid) begin
			item_s1 <= item;
		end
	end

	// result register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			result_vld_q <= 1'b0;
		end else if (out_take) begin
			result_vld_q <= vld_s1;
		end
	end

	// result register word
	always_ff @(posedge clk) begin
		if (adv_s1) begin
			result_q <= res;
		end
	end

	assign result_valid = result_vld_q;
	assign result       = result_q;

endmodule
